>>> hw/rtl/wtbm_pkg.sv
// wtbm_pkg: shared codes, defaults and result record for the weighted tag best match table
// no dependencies; used by wtbm_cost and weighted_tag_best_match_table_top
`timescale 1ns / 1ps
`default_nettype none

package wtbm_pkg;

    // default table sizes
    localparam int TYPE_COUNT_DEF  = 16;
    localparam int MAX_ENTRIES_DEF = 256;
    localparam int MAX_TAGS_DEF    = 1024;
    localparam int TAG_KINDS_DEF   = 8;

    // request codes
    localparam logic [2:0] REQ_BEGIN     = 3'd0;
    localparam logic [2:0] REQ_ADD_ENTRY = 3'd1;
    localparam logic [2:0] REQ_ADD_TAG   = 3'd2;
    localparam logic [2:0] REQ_END       = 3'd3;
    localparam logic [2:0] REQ_SET       = 3'd4;
    localparam logic [2:0] REQ_QUERY     = 3'd5;

    // status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_SEQ  = 2'd2;

    localparam logic [63:0] SAT64      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] RANGE_INIT = 32'h7FFF_FFFF;

    // one result record
    typedef struct packed {
        logic [63:0] best_score;
        logic [8:0]  slot;
        logic [1:0]  status;
    } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/weighted_tag_best_match_table_top.sv
// weighted_tag_best_match_table_top: table loader, query walker and result queue
// depends on wtbm_pkg and wtbm_cost
//
// Usage: requests arrive on the s_ stream (one request per transaction) and every
// request yields exactly one result transaction on the m_ stream.
// Requests: begin type, add entry, add tag, end type, set query element, query.
// Loads and element writes finish in the accept cycle (memory or register writes);
// their result is queued at once; one transaction per cycle while the queue has room.
// A query walks the entry memory, then the tag memory of each entry, through a
// three-stage cost pipeline.
// The walk is bounded by the single read port of each memory and the cost
// pipeline depth; one query is handled at a time.
// Results go to a two-deep queue; input is taken while the queue has room, so a
// stalled receiver holds at most two results before s_tready drops.
// Reset (aresetn low, synchronous) empties all types, zeroes match values and
// weights, sets wrap ranges to the largest positive value and clears the queue.
// Entry and tag memories are not cleared; only written locations are ever read.
`timescale 1ns / 1ps
`default_nettype none

module weighted_tag_best_match_table_top #(
    parameter int TYPE_COUNT  = wtbm_pkg::TYPE_COUNT_DEF,
    parameter int MAX_ENTRIES = wtbm_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_TAGS    = wtbm_pkg::MAX_TAGS_DEF,
    parameter int TAG_KINDS   = wtbm_pkg::TAG_KINDS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // req_type[2:0], type_id[6:3], tag_kind[9:7], tag_value[41:10],
    // weight[73:42], set_range[74], zero[79:75]
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], slot[10:2], best_score[74:11], zero[79:75]
    output logic [79:0]      m_tdata
);

    localparam int TYW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
    localparam int KW  = (TAG_KINDS > 1) ? $clog2(TAG_KINDS) : 1;
    localparam int EAW = $clog2(MAX_ENTRIES);
    localparam int ECW = $clog2(MAX_ENTRIES + 1);
    localparam int TAW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
    localparam int TCW = $clog2(MAX_TAGS + 1);

    typedef struct packed {
        logic [TCW-1:0] tag_first;
        logic [TCW-1:0] tag_past;
    } entry_t;

    typedef struct packed {
        logic [KW-1:0]      kind;
        logic signed [31:0] value;
    } tag_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ENT_RD, ST_ENT_DATA, ST_TAG_CHK, ST_TAG_DATA, ST_COST
    } state_t;

    // input fields
    logic [2:0]         in_req;
    logic [3:0]         in_tid;
    logic [2:0]         in_kind;
    logic signed [31:0] in_val;
    logic [31:0]        in_wt;
    logic               in_setr;

    assign in_req  = s_tdata[2:0];
    assign in_tid  = s_tdata[6:3];
    assign in_kind = s_tdata[9:7];
    assign in_val  = s_tdata[41:10];
    assign in_wt   = s_tdata[73:42];
    assign in_setr = s_tdata[74];

    // table state
    logic [ECW-1:0]     tt_first_reg [TYPE_COUNT];
    logic [ECW-1:0]     tt_past_reg  [TYPE_COUNT];
    logic signed [31:0] match_reg    [TAG_KINDS];
    logic [31:0]        weight_reg   [TAG_KINDS];
    logic signed [31:0] range_reg    [TAG_KINDS];
    logic [ECW-1:0]     entries_used_reg;
    logic [TCW-1:0]     tags_used_reg;
    logic               open_reg;
    logic [TYW-1:0]     open_type_reg;
    logic [ECW-1:0]     cur_entry_reg;
    logic [TCW-1:0]     cur_tfirst_reg;

    // memories
    entry_t entry_mem [MAX_ENTRIES];
    tag_t   tag_mem   [MAX_TAGS];
    entry_t entry_rdata_reg;
    tag_t   tag_rdata_reg;

    // query walk state
    state_t         state_reg;
    logic [ECW-1:0] e_reg, qpast_reg, bslot_reg;
    logic [TCW-1:0] t_reg, tpast_reg;
    logic [63:0]    sum_reg, best_reg;

    // result queue
    wtbm_pkg::res_t q0_reg, q1_reg;
    logic [1:0]     cnt_reg;
    logic           res_push, pop;
    wtbm_pkg::res_t res_data;

    logic           acc;
    logic           tid_ok, kind_ok;
    logic [TYW-1:0] tid_idx, open_idx;
    logic [KW-1:0]  kind_idx;
    logic [ECW-1:0] cur_past;
    logic [1:0]     dec_status;
    logic           dec_ok;

    logic           ent_we, tag_we;
    logic [EAW-1:0] ent_waddr;
    entry_t         ent_wdata;

    logic           cost_in_valid, cost_valid;
    logic [63:0]    cost;
    logic [64:0]    sum_wide;
    logic           win;
    logic [63:0]    fin_best;
    logic [ECW-1:0] fin_slot, e_inc;

    assign s_tready = aresetn && (state_reg == ST_IDLE) && (cnt_reg != 2'd2);
    assign acc      = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    assign tid_ok   = (32'(in_tid) < TYPE_COUNT);
    assign kind_ok  = (32'(in_kind) < TAG_KINDS);
    assign tid_idx  = TYW'(32'(in_tid));
    assign kind_idx = KW'(32'(in_kind));
    assign open_idx = open_type_reg;
    assign cur_past = tt_past_reg[open_idx];

    // request decode and immediate status
    always_comb begin
        dec_status = wtbm_pkg::STAT_SEQ;
        unique case (in_req)
            wtbm_pkg::REQ_BEGIN: begin
                if (!open_reg && tid_ok) dec_status = wtbm_pkg::STAT_OK;
            end
            wtbm_pkg::REQ_ADD_ENTRY: begin
                if (open_reg) begin
                    dec_status = (32'(cur_past) >= MAX_ENTRIES) ? wtbm_pkg::STAT_FULL
                                                                : wtbm_pkg::STAT_OK;
                end
            end
            wtbm_pkg::REQ_ADD_TAG: begin
                if (open_reg && (cur_entry_reg != '0) && kind_ok) begin
                    dec_status = (32'(tags_used_reg) >= MAX_TAGS) ? wtbm_pkg::STAT_FULL
                                                                  : wtbm_pkg::STAT_OK;
                end
            end
            wtbm_pkg::REQ_END: begin
                if (open_reg) dec_status = wtbm_pkg::STAT_OK;
            end
            wtbm_pkg::REQ_SET: begin
                if (kind_ok) dec_status = wtbm_pkg::STAT_OK;
            end
            wtbm_pkg::REQ_QUERY: begin
                if (tid_ok) dec_status = wtbm_pkg::STAT_OK;
            end
            default: dec_status = wtbm_pkg::STAT_SEQ;
        endcase
    end

    assign dec_ok = acc && (dec_status == wtbm_pkg::STAT_OK);

    // memory write port selection
    always_comb begin
        ent_we    = dec_ok && ((in_req == wtbm_pkg::REQ_ADD_ENTRY) ||
                               (in_req == wtbm_pkg::REQ_ADD_TAG));
        tag_we    = dec_ok && (in_req == wtbm_pkg::REQ_ADD_TAG);
        if (in_req == wtbm_pkg::REQ_ADD_ENTRY) begin
            ent_waddr           = cur_past[EAW-1:0];
            ent_wdata.tag_first = tags_used_reg;
            ent_wdata.tag_past  = tags_used_reg;
        end else begin
            ent_waddr           = cur_entry_reg[EAW-1:0];
            ent_wdata.tag_first = cur_tfirst_reg;
            ent_wdata.tag_past  = tags_used_reg + TCW'(1);
        end
    end

    // entry and tag memories, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (ent_we) entry_mem[ent_waddr] <= ent_wdata;
        entry_rdata_reg <= entry_mem[e_reg[EAW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (tag_we) tag_mem[tags_used_reg[TAW-1:0]] <= '{kind: kind_idx, value: in_val};
        tag_rdata_reg <= tag_mem[t_reg[TAW-1:0]];
    end

    // cost pipeline
    assign cost_in_valid = (state_reg == ST_TAG_DATA);

    wtbm_cost u_cost (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (cost_in_valid),
        .match_val  (match_reg[tag_rdata_reg.kind]),
        .wrap_range (range_reg[tag_rdata_reg.kind]),
        .tag_val    (tag_rdata_reg.value),
        .weight     (weight_reg[tag_rdata_reg.kind]),
        .out_valid  (cost_valid),
        .cost       (cost)
    );

    // entry sum, best tracking
    assign sum_wide = {1'b0, sum_reg} + {1'b0, cost};
    assign win      = (sum_reg < best_reg);
    assign fin_best = win ? sum_reg : best_reg;
    assign fin_slot = win ? e_reg : bslot_reg;
    assign e_inc    = e_reg + ECW'(1);

    // result push
    always_comb begin
        res_push            = 1'b0;
        res_data.status     = dec_status;
        res_data.slot       = '0;
        res_data.best_score = '0;
        if (acc) begin
            if (in_req == wtbm_pkg::REQ_QUERY) begin
                if (!tid_ok) begin
                    res_push = 1'b1;
                end else if (tt_first_reg[tid_idx] >= tt_past_reg[tid_idx]) begin
                    res_push            = 1'b1;
                    res_data.best_score = wtbm_pkg::SAT64;
                end
            end else begin
                res_push = 1'b1;
                if (in_req == wtbm_pkg::REQ_ADD_ENTRY &&
                    dec_status == wtbm_pkg::STAT_OK) begin
                    res_data.slot = 9'(cur_past);
                end
            end
        end else if (state_reg == ST_TAG_CHK && !(t_reg < tpast_reg) &&
                     !(e_inc < qpast_reg)) begin
            res_push            = 1'b1;
            res_data.status     = wtbm_pkg::STAT_OK;
            res_data.slot       = 9'(fin_slot);
            res_data.best_score = fin_best;
        end
    end

    // table loads and query walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            entries_used_reg <= ECW'(1);
            tags_used_reg    <= '0;
            open_reg         <= 1'b0;
            open_type_reg    <= '0;
            cur_entry_reg    <= '0;
            cur_tfirst_reg   <= '0;
            for (int i = 0; i < TYPE_COUNT; i++) begin
                tt_first_reg[i] <= '0;
                tt_past_reg[i]  <= '0;
            end
            for (int k = 0; k < TAG_KINDS; k++) begin
                match_reg[k]  <= '0;
                weight_reg[k] <= '0;
                range_reg[k]  <= wtbm_pkg::RANGE_INIT;
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (dec_ok) begin
                        unique case (in_req)
                            wtbm_pkg::REQ_BEGIN: begin
                                tt_first_reg[tid_idx] <= entries_used_reg;
                                tt_past_reg[tid_idx]  <= entries_used_reg;
                                open_reg              <= 1'b1;
                                open_type_reg         <= tid_idx;
                                cur_entry_reg         <= '0;
                            end
                            wtbm_pkg::REQ_ADD_ENTRY: begin
                                tt_past_reg[open_idx] <= cur_past + ECW'(1);
                                cur_entry_reg         <= cur_past;
                                cur_tfirst_reg        <= tags_used_reg;
                            end
                            wtbm_pkg::REQ_ADD_TAG: begin
                                tags_used_reg <= tags_used_reg + TCW'(1);
                            end
                            wtbm_pkg::REQ_END: begin
                                entries_used_reg <= cur_past;
                                open_reg         <= 1'b0;
                                cur_entry_reg    <= '0;
                            end
                            wtbm_pkg::REQ_SET: begin
                                if (in_setr) begin
                                    range_reg[kind_idx] <= in_val;
                                end else begin
                                    match_reg[kind_idx]  <= in_val;
                                    weight_reg[kind_idx] <= in_wt;
                                end
                            end
                            wtbm_pkg::REQ_QUERY: begin
                                e_reg     <= tt_first_reg[tid_idx];
                                qpast_reg <= tt_past_reg[tid_idx];
                                best_reg  <= wtbm_pkg::SAT64;
                                bslot_reg <= '0;
                                if (tt_first_reg[tid_idx] < tt_past_reg[tid_idx])
                                    state_reg <= ST_ENT_RD;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_ENT_RD: begin
                    state_reg <= ST_ENT_DATA;
                end
                ST_ENT_DATA: begin
                    t_reg     <= entry_rdata_reg.tag_first;
                    tpast_reg <= entry_rdata_reg.tag_past;
                    sum_reg   <= '0;
                    state_reg <= ST_TAG_CHK;
                end
                ST_TAG_CHK: begin
                    if (t_reg < tpast_reg) begin
                        state_reg <= ST_TAG_DATA;
                    end else begin
                        best_reg  <= fin_best;
                        bslot_reg <= fin_slot;
                        e_reg     <= e_inc;
                        state_reg <= (e_inc < qpast_reg) ? ST_ENT_RD : ST_IDLE;
                    end
                end
                ST_TAG_DATA: begin
                    state_reg <= ST_COST;
                end
                ST_COST: begin
                    if (cost_valid) begin
                        sum_reg   <= sum_wide[64] ? wtbm_pkg::SAT64 : sum_wide[63:0];
                        t_reg     <= t_reg + TCW'(1);
                        state_reg <= ST_TAG_CHK;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // two-deep result queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            case ({res_push, pop})
                2'b10: begin
                    if (cnt_reg == 2'd0) q0_reg <= res_data;
                    else                 q1_reg <= res_data;
                    cnt_reg <= cnt_reg + 2'd1;
                end
                2'b01: begin
                    q0_reg  <= q1_reg;
                    cnt_reg <= cnt_reg - 2'd1;
                end
                2'b11: begin
                    if (cnt_reg == 2'd1) begin
                        q0_reg <= res_data;
                    end else begin
                        q0_reg <= q1_reg;
                        q1_reg <= res_data;
                    end
                end
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {5'd0, q0_reg};

    // checks
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> !(cnt_reg == 2'd2 && !pop))
        else $error("result pushed into full queue");

    a_tag_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAG_CHK) |-> (t_reg <= tpast_reg))
        else $error("tag walk overran entry");

    a_ent_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ENT_RD) |-> (e_reg < qpast_reg))
        else $error("entry walk overran type");

endmodule

`default_nettype wire

>>> hw/rtl/wtbm_cost.sv
// wtbm_cost: three-stage pipeline giving the weighted wrapped distance of one tag
// uses wtbm_pkg for the saturation constant
`timescale 1ns / 1ps
`default_nettype none

module wtbm_cost (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    input  wire logic signed [31:0] match_val,
    input  wire logic signed [31:0] wrap_range,
    input  wire logic signed [31:0] tag_val,
    input  wire logic        [31:0] weight,
    output logic                    out_valid,
    output logic             [63:0] cost
);

    logic signed [34:0] a_x, r_x, b_x, ar, d0, d1;
    logic        [34:0] m0, m1;
    logic        [33:0] diff_next;
    logic        [33:0] diff_reg;
    logic        [31:0] w_reg;
    logic        [48:0] plo_reg, phi_reg;
    logic        [65:0] total;
    logic        [63:0] cost_reg;
    logic               v1_reg, v2_reg, v3_reg;

    // stage 1: direct and wrapped difference, keep the smaller magnitude
    always_comb begin
        a_x = 35'(match_val);
        r_x = 35'(wrap_range);
        b_x = 35'(tag_val);
        ar  = (match_val >= 0) ? (a_x - r_x) : (a_x + r_x);
        d0  = a_x - b_x;
        d1  = ar - b_x;
        m0  = (d0 < 0) ? 35'(-d0) : 35'(d0);
        m1  = (d1 < 0) ? 35'(-d1) : 35'(d1);
        diff_next = (m0 < m1) ? m0[33:0] : m1[33:0];
    end

    // stage 3 combine of the two partial products
    assign total = (66'(phi_reg) << 17) + 66'(plo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        diff_reg <= diff_next;
        w_reg    <= weight;
        // stage 2: split multiply
        plo_reg  <= 49'(diff_reg[16:0]) * 49'(w_reg);
        phi_reg  <= 49'(diff_reg[33:17]) * 49'(w_reg);
        // stage 3: saturate to 64 bits
        cost_reg <= (|total[65:64]) ? wtbm_pkg::SAT64 : total[63:0];
    end

    assign out_valid = v3_reg;
    assign cost      = cost_reg;

endmodule

`default_nettype wire

>>> dv/weighted_tag_best_match_table_top_test.sv
// weighted_tag_best_match_table_top_test: self-checking testbench for the tag best match table
// depends on wtbm_pkg and weighted_tag_best_match_table_top; predicts every result in place
`timescale 1ns / 1ps

module weighted_tag_best_match_table_top_test;

    localparam int NTYPES = wtbm_pkg::TYPE_COUNT_DEF;
    localparam int NENT   = wtbm_pkg::MAX_ENTRIES_DEF;
    localparam int NTAGS  = wtbm_pkg::MAX_TAGS_DEF;
    localparam int NKINDS = wtbm_pkg::TAG_KINDS_DEF;
    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    weighted_tag_best_match_table_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // shadow copy of the table state
    logic [8:0]         ty_first [NTYPES];
    logic [8:0]         ty_past  [NTYPES];
    logic [10:0]        ent_tfirst [NENT];
    logic [10:0]        ent_tpast  [NENT];
    logic [8:0]         ent_slot   [NENT];
    logic [2:0]         tag_kind_mem [NTAGS];
    logic signed [31:0] tag_val_mem  [NTAGS];
    logic signed [31:0] match_val [NKINDS];
    logic [31:0]        kind_wt   [NKINDS];
    logic signed [31:0] wrap_rng  [NKINDS];
    int unsigned        next_entry, next_tag, next_slot, cur_entry, open_id;
    bit                 is_open;

    wtbm_pkg::res_t pending_results[$];
    int   fail_count = 0;
    int   items_sent = 0;
    int   queries_sent = 0;
    int   fulls_seen = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;

    // clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge aclk) begin
        wtbm_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.status || m_tdata[10:2] !== want.slot ||
                    m_tdata[74:11] !== want.best_score) begin
                    $display("%0t: mismatch exp st=%0d slot=%0d score=%h act st=%0d slot=%0d score=%h",
                             $time, want.status, want.slot, want.best_score,
                             m_tdata[1:0], m_tdata[10:2], m_tdata[74:11]);
                    fail_count++;
                end
            end
        end
    end

    task automatic clear_shadow();
        for (int k = 0; k < NTYPES; k++) begin
            ty_first[k] = '0;
            ty_past[k] = '0;
        end
        for (int k = 0; k < NKINDS; k++) begin
            match_val[k] = '0;
            kind_wt[k] = '0;
            wrap_rng[k] = wtbm_pkg::RANGE_INIT;
        end
        next_entry = 1;
        next_tag = 0;
        next_slot = 1;
        cur_entry = 0;
        open_id = 0;
        is_open = 0;
    endtask

    // weighted distance of one tag, saturating
    function automatic logic [63:0] tag_distance(int unsigned k, logic signed [31:0] b);
        logic signed [63:0] a, r, d0, d1;
        logic [63:0]  m0, m1, diff;
        logic [127:0] prod;
        a = match_val[k];
        r = wrap_rng[k];
        d0 = a - b;
        d1 = ((a >= 0) ? a - r : a + r) - b;
        m0 = (d0 < 0) ? -d0 : d0;
        m1 = (d1 < 0) ? -d1 : d1;
        diff = (m0 < m1) ? m0 : m1;
        prod = diff * {96'd0, kind_wt[k]};
        return (prod[127:64] != 0) ? wtbm_pkg::SAT64 : prod[63:0];
    endfunction

    // apply one request to the shadow state and return its result
    function automatic wtbm_pkg::res_t apply_request(logic [2:0] req, logic [3:0] tid,
                                                     logic [2:0] kind, logic signed [31:0] val,
                                                     logic [31:0] wt, bit setr);
        wtbm_pkg::res_t res;
        logic [63:0] best, sum, c;
        int unsigned idx;
        res = '{best_score: 64'd0, slot: 9'd0, status: wtbm_pkg::STAT_SEQ};
        case (req)
            wtbm_pkg::REQ_BEGIN: begin
                if (!is_open) begin
                    ty_first[tid] = 9'(next_entry);
                    ty_past[tid] = 9'(next_entry);
                    is_open = 1;
                    open_id = tid;
                    cur_entry = 0;
                    res.status = wtbm_pkg::STAT_OK;
                end
            end
            wtbm_pkg::REQ_ADD_ENTRY: begin
                if (is_open) begin
                    idx = ty_past[open_id];
                    if (idx >= NENT || next_slot >= NENT) begin
                        res.status = wtbm_pkg::STAT_FULL;
                    end else begin
                        ent_tfirst[idx] = 11'(next_tag);
                        ent_tpast[idx] = 11'(next_tag);
                        ent_slot[idx] = 9'(next_slot);
                        res.slot = 9'(next_slot);
                        next_slot++;
                        ty_past[open_id] = 9'(idx + 1);
                        cur_entry = idx;
                        res.status = wtbm_pkg::STAT_OK;
                    end
                end
            end
            wtbm_pkg::REQ_ADD_TAG: begin
                if (is_open && cur_entry != 0) begin
                    if (next_tag >= NTAGS) begin
                        res.status = wtbm_pkg::STAT_FULL;
                    end else begin
                        tag_kind_mem[next_tag] = kind;
                        tag_val_mem[next_tag] = val;
                        next_tag++;
                        ent_tpast[cur_entry] = ent_tpast[cur_entry] + 11'd1;
                        res.status = wtbm_pkg::STAT_OK;
                    end
                end
            end
            wtbm_pkg::REQ_END: begin
                if (is_open) begin
                    next_entry = ty_past[open_id];
                    is_open = 0;
                    cur_entry = 0;
                    res.status = wtbm_pkg::STAT_OK;
                end
            end
            wtbm_pkg::REQ_SET: begin
                if (setr) begin
                    wrap_rng[kind] = val;
                end else begin
                    match_val[kind] = val;
                    kind_wt[kind] = wt;
                end
                res.status = wtbm_pkg::STAT_OK;
            end
            wtbm_pkg::REQ_QUERY: begin
                best = wtbm_pkg::SAT64;
                for (int e = ty_first[tid]; e < ty_past[tid]; e++) begin
                    sum = '0;
                    for (int t = ent_tfirst[e]; t < ent_tpast[e]; t++) begin
                        c = tag_distance(tag_kind_mem[t], tag_val_mem[t]);
                        sum = (sum > wtbm_pkg::SAT64 - c) ? wtbm_pkg::SAT64 : sum + c;
                    end
                    if (sum < best) begin
                        best = sum;
                        res.slot = ent_slot[e];
                    end
                end
                res.best_score = best;
                res.status = wtbm_pkg::STAT_OK;
            end
            default: ;
        endcase
        return res;
    endfunction

    // send one transaction, with random idle cycles in front
    task automatic send_request(input logic [2:0] req, input logic [3:0] tid,
                                input logic [2:0] kind, input logic [31:0] val,
                                input logic [31:0] wt, input bit setr,
                                output wtbm_pkg::res_t res);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, setr, wt, val, kind, tid, req};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = apply_request(req, tid, kind, val, wt, setr);
        pending_results.push_back(res);
        items_sent++;
        if (req == wtbm_pkg::REQ_QUERY) queries_sent++;
        if (res.status == wtbm_pkg::STAT_FULL) fulls_seen++;
    endtask

    task automatic req_simple(logic [2:0] req, logic [3:0] tid);
        wtbm_pkg::res_t r;
        send_request(req, tid, '0, '0, '0, 1'b0, r);
    endtask

    task automatic req_tag(logic [2:0] kind, logic [31:0] val);
        wtbm_pkg::res_t r;
        send_request(wtbm_pkg::REQ_ADD_TAG, '0, kind, val, '0, 1'b0, r);
    endtask

    task automatic req_set(logic [2:0] kind, logic [31:0] val, logic [31:0] wt, bit setr);
        wtbm_pkg::res_t r;
        send_request(wtbm_pkg::REQ_SET, '0, kind, val, wt, setr, r);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return $urandom_range(32'h0003_0000) - 32'h0001_8000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(4))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0000_0000;
            2: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    // initial state, idle-side errors and unused codes
    task automatic test_reset_state();
        req_simple(wtbm_pkg::REQ_QUERY, 4'd0);
        req_simple(wtbm_pkg::REQ_QUERY, 4'd15);
        req_simple(wtbm_pkg::REQ_END, 4'd0);
        req_simple(wtbm_pkg::REQ_ADD_ENTRY, 4'd0);
        req_tag(3'd0, 32'd5);
        req_simple(REQ_SPARE6, 4'd3);
        req_simple(REQ_SPARE7, 4'd9);
    endtask

    // sequence errors, extremes, sign of zero, ties and saturation
    task automatic test_directed();
        req_simple(wtbm_pkg::REQ_BEGIN, 4'd15);
        req_simple(wtbm_pkg::REQ_BEGIN, 4'd2);
        req_tag(3'd1, 32'd1);
        req_simple(wtbm_pkg::REQ_ADD_ENTRY, 4'd0);
        req_tag(3'd0, 32'h8000_0000);
        req_tag(3'd7, 32'h7FFF_FFFF);
        req_simple(wtbm_pkg::REQ_ADD_ENTRY, 4'd0);
        req_tag(3'd0, 32'h8000_0000);
        req_tag(3'd7, 32'h7FFF_FFFF);
        req_simple(wtbm_pkg::REQ_QUERY, 4'd15);
        req_simple(wtbm_pkg::REQ_END, 4'd0);
        req_set(3'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        req_set(3'd7, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        req_simple(wtbm_pkg::REQ_QUERY, 4'd15);
        req_set(3'd7, 32'h0001_0000, 32'h0000_8000, 1'b0);
        req_set(3'd0, 32'h0000_0000, 32'h0001_0000, 1'b0);
        req_set(3'd0, 32'h0004_0000, 32'd0, 1'b1);
        req_set(3'd7, 32'h8000_0000, 32'd0, 1'b1);
        req_simple(wtbm_pkg::REQ_QUERY, 4'd15);
        req_simple(wtbm_pkg::REQ_QUERY, 4'd2);
    endtask

    // well-formed type builds with random content, plus noise
    task automatic test_random(int target);
        wtbm_pkg::res_t r;
        int   start, n_ent, n_tag;
        start = items_sent;
        while (items_sent - start < target) begin
            if (items_sent - start < target / 3) begin
                send_idle_pct = 29;
                recv_idle_pct = 71;
            end else if (items_sent - start < 2 * target / 3) begin
                send_idle_pct = 71;
                recv_idle_pct = 29;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(99) < 80) begin
                req_simple(wtbm_pkg::REQ_BEGIN, 4'($urandom_range(15)));
                n_ent = $urandom_range(4, 1);
                for (int e = 0; e < n_ent; e++) begin
                    req_simple(wtbm_pkg::REQ_ADD_ENTRY, 4'($urandom_range(15)));
                    n_tag = $urandom_range(3);
                    for (int t = 0; t < n_tag; t++)
                        req_tag(3'($urandom_range(7)), pick_value());
                end
                if ($urandom_range(3) == 0)
                    req_simple(wtbm_pkg::REQ_QUERY, 4'($urandom_range(15)));
                req_simple(wtbm_pkg::REQ_END, 4'($urandom_range(15)));
                for (int s = $urandom_range(2); s >= 0; s--)
                    req_set(3'($urandom_range(7)), pick_value(), pick_weight(),
                            $urandom_range(3) == 0);
                for (int q = $urandom_range(2, 1); q > 0; q--)
                    req_simple(wtbm_pkg::REQ_QUERY, 4'($urandom_range(15)));
            end else begin
                send_request(3'($urandom_range(7)), 4'($urandom_range(15)),
                             3'($urandom_range(7)), $urandom, $urandom,
                             1'($urandom_range(1)), r);
            end
        end
    endtask

    // sender holds off until the result queue has drained
    task automatic test_drain_pause();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        req_simple(wtbm_pkg::REQ_QUERY, 4'($urandom_range(15)));
    endtask

    // run the entry store into its limit, then tag the last entry
    task automatic test_fill();
        wtbm_pkg::res_t r;
        if (is_open) req_simple(wtbm_pkg::REQ_END, 4'd0);
        req_simple(wtbm_pkg::REQ_BEGIN, 4'd5);
        r.status = wtbm_pkg::STAT_OK;
        while (r.status != wtbm_pkg::STAT_FULL)
            send_request(wtbm_pkg::REQ_ADD_ENTRY, '0, '0, '0, '0, 1'b0, r);
        for (int t = 0; t < 8; t++)
            req_tag(3'($urandom_range(7)), pick_value());
        req_simple(wtbm_pkg::REQ_ADD_ENTRY, 4'd0);
        req_simple(wtbm_pkg::REQ_END, 4'd0);
        req_simple(wtbm_pkg::REQ_QUERY, 4'd5);
    endtask

    initial begin
        clear_shadow();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 29;
        recv_idle_pct = 71;
        test_reset_state();
        test_directed();
        test_random(300);
        test_drain_pause();
        test_fill();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("covered %0d requests, %0d queries, %0d store-full answers",
                 items_sent, queries_sent, fulls_seen);
        $display("idle mixes: sender-light, receiver-light and back-to-back");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> weighted_tag_best_match_table_top.f
hw/rtl/wtbm_pkg.sv
hw/rtl/wtbm_cost.sv
hw/rtl/weighted_tag_best_match_table_top.sv
dv/weighted_tag_best_match_table_top_test.sv
